// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/bwcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bwcd_pkg
// Types, widths, state encodings and the block weight table.
// ----------------------------------------------------------------------------
package bwcd_pkg;

  localparam int ACC_W     = 48;
  localparam int SCORE_W   = 24;
  localparam int IDX_W     = 6;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 17;
  localparam int CFG_W     = 6;
  localparam int TABLE_LEN = 40;
  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RESET = 6'd40;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        te;
    logic [ACC_W-1:0]        qe;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } blk_rec_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SQRT, B_DIV, B_WEIGHT, B_ACC, B_FINAL, B_EMIT
  } back_state_t;

  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [IDX_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    case (idx)
      6'd0:  w = 16'd59638;  6'd1:  w = 16'd57672;  6'd2:  w = 16'd57672;
      6'd3:  w = 16'd59638;  6'd4:  w = 16'd63570;  6'd5:  w = 16'd64225;
      6'd6:  w = 16'd64225;  6'd7:  w = 16'd63570;  6'd8:  w = 16'd60948;
      6'd9:  w = 16'd65535;  6'd10: w = 16'd65535;  6'd11: w = 16'd60948;
      6'd12: w = 16'd58327;  6'd13: w = 16'd63570;  6'd14: w = 16'd63570;
      6'd15: w = 16'd58327;  6'd16: w = 16'd55050;  6'd17: w = 16'd62259;
      6'd18: w = 16'd62259;  6'd19: w = 16'd55050;  6'd20: w = 16'd48497;
      6'd21: w = 16'd59638;  6'd22: w = 16'd59638;  6'd23: w = 16'd48497;
      6'd24: w = 16'd50463;  6'd25: w = 16'd58327;  6'd26: w = 16'd58327;
      6'd27: w = 16'd50463;  6'd28: w = 16'd52429;  6'd29: w = 16'd55706;
      6'd30: w = 16'd55706;  6'd31: w = 16'd52429;  6'd32: w = 16'd53084;
      6'd33: w = 16'd53740;  6'd34: w = 16'd53740;  6'd35: w = 16'd53084;
      6'd36: w = 16'd50463;  6'd37: w = 16'd52429;  6'd38: w = 16'd52429;
      6'd39: w = 16'd50463;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/bwcd_queue.sv -----
// ----------------------------------------------------------------------------
// bwcd_queue
// Two-entry queue of closed block records between the front and back ends.
// ----------------------------------------------------------------------------
module bwcd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bwcd_pkg::blk_rec_t push_rec,
  input  logic               pop,
  output bwcd_pkg::blk_rec_t head_rec,
  output logic               full,
  output logic               empty
);
  import bwcd_pkg::*;

  blk_rec_t   entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head_rec = entry_r[rd_ptr_r];
  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/bwcd_front.sv -----
// ----------------------------------------------------------------------------
// bwcd_front
// Takes element pairs, forms the products and accumulates one block.
// ----------------------------------------------------------------------------
module bwcd_front #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ELEMENT_BITS-1:0] target_element,
  input  logic signed [ELEMENT_BITS-1:0] query_element,
  input  logic                           last_in_block,
  input  logic                           last_of_vector,
  input  logic                           q_full,
  output logic                           q_push,
  output bwcd_pkg::blk_rec_t             q_rec
);
  import bwcd_pkg::*;

  localparam int PW = 2 * ELEMENT_BITS;
  localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam logic signed [SW-1:0] DMAX = {{(SW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SW-1:0] DMIN = ~DMAX;
  localparam logic [SW-1:0]        EMAX = {{(SW-ACC_W){1'b0}}, {ACC_W{1'b1}}};

  front_state_t state_r, state_nxt;
  logic signed [ELEMENT_BITS-1:0] t_r, q_r;
  logic blk_end_r, vec_end_r;
  logic signed [PW-1:0] ptq_r, ptt_r, pqq_r;
  logic signed [ACC_W-1:0] dot_r;
  logic [ACC_W-1:0] te_r, qe_r;
  logic [IDX_W-1:0] idx_r;

  logic accept, closing, finish;
  logic signed [SW-1:0] dsum;
  logic [SW-1:0] tsum, qsum;
  logic signed [ACC_W-1:0] dot_sat;
  logic [ACC_W-1:0] te_sat, qe_sat;

  assign closing  = blk_end_r | vec_end_r;
  assign finish   = (state_r == F_ACC) && !(closing && q_full);
  assign in_stall = !((state_r == F_IDLE) || finish);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    dsum = SW'(dot_r) + SW'(ptq_r);
    tsum = SW'(te_r) + SW'(unsigned'(ptt_r));
    qsum = SW'(qe_r) + SW'(unsigned'(pqq_r));
    if (dsum > DMAX)      dot_sat = DMAX[ACC_W-1:0];
    else if (dsum < DMIN) dot_sat = DMIN[ACC_W-1:0];
    else                  dot_sat = dsum[ACC_W-1:0];
    te_sat = (tsum > EMAX) ? EMAX[ACC_W-1:0] : tsum[ACC_W-1:0];
    qe_sat = (qsum > EMAX) ? EMAX[ACC_W-1:0] : qsum[ACC_W-1:0];
  end

  assign q_push = finish && closing;
  assign q_rec  = '{dot: dot_sat, te: te_sat, qe: qe_sat, idx: idx_r, last: vec_end_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_ACC;
      F_ACC: begin
        if (accept)      state_nxt = F_MUL;
        else if (finish) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r       <= target_element;
      q_r       <= query_element;
      blk_end_r <= last_in_block;
      vec_end_r <= last_of_vector;
    end
    if (state_r == F_MUL) begin
      ptq_r <= t_r * q_r;
      ptt_r <= t_r * t_r;
      pqq_r <= q_r * q_r;
    end
    if (!rst_n) begin
      state_r <= F_IDLE;
      dot_r   <= '0;
      te_r    <= '0;
      qe_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        if (closing) begin
          dot_r <= '0;
          te_r  <= '0;
          qe_r  <= '0;
          if (vec_end_r)            idx_r <= '0;
          else if (idx_r != '1)     idx_r <= idx_r + 1'b1;
        end else begin
          dot_r <= dot_sat;
          te_r  <= te_sat;
          qe_r  <= qe_sat;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/bwcd_back.sv -----
// ----------------------------------------------------------------------------
// bwcd_back
// Per block: energy product, square root, cosine divide, weighting, score;
// zero-energy blocks: score only. Per vector: scaling divide, output register.
// ----------------------------------------------------------------------------
module bwcd_back #(
  parameter int BLOCKS = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bwcd_pkg::CFG_W-1:0]    blocks_in_use,
  input  logic                          q_empty,
  input  bwcd_pkg::blk_rec_t            q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bwcd_pkg::DIST_W-1:0]   distance,
  output logic                          zero_norm_seen
);
  import bwcd_pkg::*;

  localparam int FN_W = 26;

  back_state_t state_r, state_nxt;
  blk_rec_t    rec_r;
  logic [6:0]  cnt_r;
  logic [2*ACC_W-1:0] mc_r, prod_r;
  logic [ACC_W-1:0]   mp_r, root_r, mag_r;
  logic [ACC_W+2:0]   rem_r;
  logic [ACC_W-1:0]   dr_r;
  logic [63:0]        num_r;
  logic               neg_r, zf_r;
  logic [17:0]        term_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [FN_W-1:0]    fnum_r;
  logic [6:0]         fdiv_r, frem_r;
  logic               out_valid_r, out_zero_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic out_load, zero_blk, cnt_done;
  logic [ACC_W+2:0] rem_sh, trial;
  logic [ACC_W:0]   dr_sh;
  logic [ACC_W-1:0] root_nxt;
  logic             div_ge;
  logic [16:0]      cos_c;
  logic [WEIGHT_W-1:0] w;
  logic [33:0]      wprod;
  logic signed [SCORE_W+1:0] ssum;
  logic signed [SCORE_W-1:0] score_nxt;
  logic [CFG_W-1:0] b;
  logic signed [FN_W:0] fnum;
  logic [7:0]       frem_sh;
  logic             f_ge;

  assign zero_blk = (q_head.te == '0) || (q_head.qe == '0);
  assign cnt_done = cnt_r == '0;

  always_comb begin
    rem_sh   = {rem_r[ACC_W:0], prod_r[2*ACC_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    root_nxt = (rem_sh >= trial) ? {root_r[ACC_W-2:0], 1'b1} : {root_r[ACC_W-2:0], 1'b0};
    dr_sh    = {dr_r, num_r[63]};
    div_ge   = dr_sh >= {1'b0, root_r};
    cos_c    = (num_r > 64'd65536) ? 17'd65536 : num_r[16:0];
    w        = ({1'b0, rec_r.idx} < 7'(BLOCKS)) ? weight_of(rec_r.idx) : '0;
    wprod    = 34'(cos_c) * 34'(w) + 34'd32768;
    ssum     = (SCORE_W+2)'(score_r)
             + (neg_r ? -(SCORE_W+2)'(term_r) : (SCORE_W+2)'(term_r));
    if (ssum > (SCORE_W+2)'(signed'({1'b0, {(SCORE_W-1){1'b1}}})))
      score_nxt = {1'b0, {(SCORE_W-1){1'b1}}};
    else if (ssum < -(SCORE_W+2)'(signed'({1'b0, 1'b1, {(SCORE_W-1){1'b0}}})))
      score_nxt = {1'b1, {(SCORE_W-1){1'b0}}};
    else
      score_nxt = ssum[SCORE_W-1:0];
    b        = (blocks_in_use == '0) ? CFG_W'(1) : blocks_in_use;
    fnum     = (FN_W+1)'({b, 16'b0}) + (FN_W+1)'(b) - (FN_W+1)'(score_nxt);
    frem_sh  = {frem_r, fnum_r[FN_W-1]};
    f_ge     = frem_sh >= {1'b0, fdiv_r};
  end

  // Control outputs
  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_empty;
    out_load = (state_r == B_EMIT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (q_pop) state_nxt = zero_blk ? B_ACC : B_MUL;
      B_MUL:    if (cnt_done) state_nxt = B_SQRT;
      B_SQRT:   if (cnt_done) state_nxt = B_DIV;
      B_DIV:    if (cnt_done) state_nxt = B_WEIGHT;
      B_WEIGHT: state_nxt = B_ACC;
      B_ACC:    state_nxt = rec_r.last ? B_FINAL : B_IDLE;
      B_FINAL:  if (cnt_done) state_nxt = B_EMIT;
      B_EMIT:   if (out_load) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          rec_r  <= q_head;
          mc_r   <= {{ACC_W{1'b0}}, q_head.te};
          mp_r   <= q_head.qe;
          prod_r <= '0;
          neg_r  <= q_head.dot[ACC_W-1];
          mag_r  <= q_head.dot[ACC_W-1] ? ACC_W'(-q_head.dot) : ACC_W'(q_head.dot);
          term_r <= '0;
          cnt_r  <= 7'(ACC_W - 1);
        end
      end
      B_MUL: begin
        if (mp_r[0]) prod_r <= prod_r + mc_r;
        mc_r  <= {mc_r[2*ACC_W-2:0], 1'b0};
        mp_r  <= {1'b0, mp_r[ACC_W-1:1]};
        cnt_r <= cnt_done ? 7'(ACC_W - 1) : cnt_r - 1'b1;
        if (cnt_done) begin
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      B_SQRT: begin
        rem_r  <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_r <= root_nxt;
        prod_r <= {prod_r[2*ACC_W-3:0], 2'b00};
        cnt_r  <= cnt_done ? 7'd63 : cnt_r - 1'b1;
        if (cnt_done) begin
          num_r <= {mag_r, 16'b0} + 64'(root_nxt[ACC_W-1:1]);
          dr_r  <= '0;
        end
      end
      B_DIV: begin
        dr_r  <= div_ge ? ACC_W'(dr_sh - {1'b0, root_r}) : dr_sh[ACC_W-1:0];
        num_r <= {num_r[62:0], div_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      B_WEIGHT: term_r <= wprod[33:16];
      B_ACC: begin
        fnum_r <= fnum[FN_W] ? '0 : fnum[FN_W-1:0];
        fdiv_r <= {b, 1'b0};
        frem_r <= '0;
        cnt_r  <= 7'(FN_W - 1);
      end
      B_FINAL: begin
        frem_r <= f_ge ? 7'(frem_sh - {1'b0, fdiv_r}) : frem_sh[6:0];
        fnum_r <= {fnum_r[FN_W-2:0], f_ge};
        cnt_r  <= cnt_r - 1'b1;
      end
      B_EMIT: ;
      default: ;
    endcase
    if (out_load) begin
      out_dist_r <= (fnum_r > FN_W'(65536)) ? 17'd65536 : fnum_r[16:0];
      out_zero_r <= zf_r;
    end
    if (!rst_n) begin
      state_r     <= B_IDLE;
      score_r     <= '0;
      zf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && zero_blk) zf_r <= 1'b1;
      if (state_r == B_ACC) score_r <= score_nxt;
      if (out_load) begin
        score_r <= '0;
        zf_r    <= 1'b0;
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign distance       = out_dist_r;
  assign zero_norm_seen = out_zero_r;
endmodule

// ----- hw/rtl/blockwise_weighted_cosine_distance.sv -----
// ----------------------------------------------------------------------------
// blockwise_weighted_cosine_distance
// Weighted blockwise cosine distance between a target and a query vector.
// ----------------------------------------------------------------------------
// The block takes one element pair per transaction and returns one distance
// transaction per vector. The front end takes a new element only once the
// products of the last are formed: state F_MUL forms the three products in its
// multipliers and state F_ACC, in which the next element may be taken, adds
// them into the saturating block accumulators. When a block closes, its sums go
// into a two-entry queue. The back end takes each record from the queue and,
// if neither energy is zero, runs a shift-add energy product, a bit-pair square
// root, a restoring cosine divide, a weighting step and a score step. At the end
// of a vector, a further divide scales the score and the result is loaded into
// the output register. Blocks of 82 or more elements stream unless the output
// stalls; shorter blocks stall the input while the queue is full. The single
// register, blocks_in_use, is written through the configuration port, which is
// always ready, and must only change while no vector is in flight.
module blockwise_weighted_cosine_distance #(
  parameter int BLOCKS       = 40,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ELEMENT_BITS-1:0] in_target_element,
  input  logic signed [ELEMENT_BITS-1:0] in_query_element,
  input  logic                           in_last_in_block,
  input  logic                           in_last_of_vector,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bwcd_pkg::DIST_W-1:0]    out_distance,
  output logic                           out_zero_norm_seen,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwcd_pkg::CFG_W-1:0]     cfg_blocks_in_use
);
  import bwcd_pkg::*;
  `include "assert_macros.svh"

  logic [CFG_W-1:0] blocks_in_use_r;
  logic     q_push, q_pop, q_full, q_empty;
  blk_rec_t q_push_rec, q_head;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BLOCKS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blocks_in_use_r <= cfg_blocks_in_use;
    end
  end

  // Front end: element products and block accumulation.
  bwcd_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_element (in_target_element),
    .query_element  (in_query_element),
    .last_in_block  (in_last_in_block),
    .last_of_vector (in_last_of_vector),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_push_rec)
  );

  // Closed blocks wait here so that both ends can stall independently.
  bwcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .head_rec (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: cosine, weighting, score and final distance.
  bwcd_back #(.BLOCKS(BLOCKS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .blocks_in_use  (blocks_in_use_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distance       (out_distance),
    .zero_norm_seen (out_zero_norm_seen)
  );

  // A block record is never written into a full queue.
  `ASSERT_SAME(a_no_overflow, clk, rst_n, q_push, !q_full, "block queue overflow")
  // The back end only takes a record that is present.
  `ASSERT_SAME(a_no_underflow, clk, rst_n, q_pop, !q_empty, "block queue underflow")
  // After an element is taken, the front end is busy forming its products.
  `ASSERT_NEXT(a_front_busy, clk, rst_n, in_valid && !in_stall, in_stall,
    "front end accepted two elements in a row")
endmodule
